// File: rtl/owsbr_pkg.sv
`default_nettype none
package owsbr_pkg;

  localparam int ByteW  = 8;
  localparam int CountW = 8;
  localparam int BitsW  = 4;
  localparam int PhaseW = 3;
  localparam int CfgIdxW = 1;

  localparam logic [PhaseW-1:0] PH_IDLE  = 3'd0;
  localparam logic [PhaseW-1:0] PH_BEGIN = 3'd1;
  localparam logic [PhaseW-1:0] PH_RESET = 3'd2;
  localparam logic [PhaseW-1:0] PH_READ  = 3'd3;
  localparam logic [PhaseW-1:0] PH_DONE  = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_SAMPLE_POINT = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_RESET_POINT  = 1'd1;

  localparam logic [CountW-1:0] SAMPLE_POINT_RST = 8'd4;
  localparam logic [CountW-1:0] RESET_POINT_RST  = 8'd68;

  typedef struct packed {
    logic line_level;
    logic host_ack;
  } in_t;

  typedef struct packed {
    logic              byte_ready;
    logic [ByteW-1:0]  byte_value;
    logic [PhaseW-1:0] phase;
  } out_t;

endpackage
`default_nettype wire

// File: rtl/owsbr_core.sv
`default_nettype none
module owsbr_core
  import owsbr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CountW-1:0]  cfg_wdata,
  input  wire logic               step,
  input  wire in_t                step_data,
  output out_t                    result
);

  logic [CountW-1:0] sample_point_r, reset_point_r;
  logic              prev_level_r;
  logic [CountW-1:0] tick_r, tick_nxt;
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [ByteW-1:0]  shift_r, shift_nxt;
  logic [BitsW-1:0]  bits_r, bits_nxt;
  logic [ByteW-1:0]  held_r, held_nxt;
  logic              ready_r, ready_nxt;
  logic              lvl;
  logic              rise;

  assign lvl  = step_data.line_level;
  assign rise = lvl & ~prev_level_r;

  always_comb begin
    tick_nxt  = tick_r;
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    held_nxt  = held_r;
    ready_nxt = step_data.host_ack ? 1'b0 : ready_r;
    if (rise) begin
      tick_nxt = '0;
      case (phase_r)
        PH_IDLE:  phase_nxt = PH_BEGIN;
        PH_RESET: phase_nxt = PH_READ;
        PH_DONE:  phase_nxt = PH_IDLE;
        default:  phase_nxt = phase_r;
      endcase
    end else begin
      tick_nxt = tick_r + 1'b1;
      if (tick_nxt == sample_point_r && phase_nxt == PH_READ) begin
        shift_nxt = {~lvl, shift_r[ByteW-1:1]};
        bits_nxt  = bits_r + 1'b1;
        if (bits_nxt[BitsW-1]) begin
          phase_nxt = PH_DONE;
          held_nxt  = shift_nxt;
          ready_nxt = 1'b1;
        end
      end
      if (tick_nxt == reset_point_r) begin
        if (phase_nxt == PH_BEGIN && lvl) begin
          phase_nxt = PH_RESET;
          shift_nxt = '0;
          bits_nxt  = '0;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      if (tick_nxt == '0 && phase_nxt != PH_RESET) begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  assign result.byte_ready = ready_nxt;
  assign result.byte_value = held_nxt;
  assign result.phase      = phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_point_r <= SAMPLE_POINT_RST;
      reset_point_r  <= RESET_POINT_RST;
      prev_level_r   <= 1'b0;
      tick_r         <= '0;
      phase_r        <= PH_IDLE;
      shift_r        <= '0;
      bits_r         <= '0;
      held_r         <= '0;
      ready_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SAMPLE_POINT: sample_point_r <= cfg_wdata;
          REG_RESET_POINT:  reset_point_r  <= cfg_wdata;
          default:          ;
        endcase
      end
      if (step) begin
        prev_level_r <= lvl;
        tick_r       <= tick_nxt;
        phase_r      <= phase_nxt;
        shift_r      <= shift_nxt;
        bits_r       <= bits_nxt;
        held_r       <= held_nxt;
        ready_r      <= ready_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/owsbr_out_buf.sv
`default_nettype none
module owsbr_out_buf
  import owsbr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire out_t push_data,
  output logic      space,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  logic out_valid_r, skid_valid_r;
  out_t out_data_r, skid_data_r;
  logic pop;

  assign pop       = out_valid_r & out_ready;
  assign space     = ~skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_r <= push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r  <= skid_data_r;
        skid_data_r <= push_data;
      end
    end else if (!out_valid_r || pop) begin
      out_data_r <= push_data;
    end else begin
      skid_data_r <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/onewire_slave_byte_receiver_core.sv
// One-wire slave byte receiver, stepped once per prescaled timer tick.
// Each request on the in_ channel carries the sampled line level (1 means
// the line is pulled active) and the host acknowledge for the ready flag.
// Each request produces exactly one result on the out_ channel: the ready
// flag, the last complete byte and the bus phase after that tick.
// The tick is evaluated at the edge where it is accepted, and its result is
// registered into the output buffer at that same edge.
// While in_ready is high a new request is accepted every cycle.
// The state update is a single pass of compare and shift logic on the
// state registers, so nothing limits the rate but the output buffer.
// A two-entry output buffer decouples the channels; in_ready drops only
// when both entries hold results the receiver has not taken yet.
// The cfg_ port writes the sample point (index 0) and the reset point
// (index 1) whenever cfg_we is high.
// Synchronous reset clears the state, empties the buffer and restores the
// sample point to 4 and the reset point to 68.
`default_nettype none
module onewire_slave_byte_receiver_core
  import owsbr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CountW-1:0]  cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_t                in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_t                    out_data
);

  logic accept;
  out_t result;

  assign accept = in_valid & in_ready;

  owsbr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (accept),
    .step_data (in_data),
    .result    (result)
  );

  owsbr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: tb/onewire_slave_byte_receiver_core_tb.sv
module onewire_slave_byte_receiver_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import owsbr_pkg::*;

  localparam int IdleLimit     = 2000;
  localparam int HoldOffCycles = 200;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CountW-1:0]   cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_data;
  logic                out_valid;
  logic                out_ready;
  out_t                out_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off_left  = 0;
  int ticks_sent     = 0;
  int fail_count     = 0;
  int quiet_cycles   = 0;

  out_t expected_reports[$];

  // Shadow copy of the receiver state and its two compare points.
  logic                prev_lvl  = 1'b0;
  logic [CountW-1:0]   tick_cnt  = '0;
  logic [PhaseW-1:0]   bus_ph    = PH_IDLE;
  logic [ByteW-1:0]    shift_reg = '0;
  logic [BitsW-1:0]    bit_cnt   = '0;
  logic [ByteW-1:0]    rx_byte   = '0;
  logic                rdy_flag  = 1'b0;
  logic [CountW-1:0]   samp_pt   = SAMPLE_POINT_RST;
  logic [CountW-1:0]   rst_pt    = RESET_POINT_RST;

  always #1 clk = ~clk;

  onewire_slave_byte_receiver_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  function automatic out_t advance_receiver_model(in_t req);
    out_t rep;
    if (req.host_ack) rdy_flag = 1'b0;
    if (req.line_level && !prev_lvl) begin
      tick_cnt = '0;
      case (bus_ph)
        PH_IDLE:  bus_ph = PH_BEGIN;
        PH_RESET: bus_ph = PH_READ;
        PH_DONE:  bus_ph = PH_IDLE;
        default: ;
      endcase
    end else begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt == samp_pt && bus_ph == PH_READ) begin
        shift_reg = {~req.line_level, shift_reg[ByteW-1:1]};
        bit_cnt = bit_cnt + 1'b1;
        if (bit_cnt > 4'd7) begin
          bus_ph = PH_DONE;
          rx_byte = shift_reg;
          rdy_flag = 1'b1;
        end
      end
      if (tick_cnt == rst_pt) begin
        if (bus_ph == PH_BEGIN && req.line_level) begin
          bus_ph = PH_RESET;
          shift_reg = '0;
          bit_cnt = '0;
        end else begin
          bus_ph = PH_IDLE;
        end
      end
      if (tick_cnt == '0 && bus_ph != PH_RESET) bus_ph = PH_IDLE;
    end
    prev_lvl = req.line_level;
    rep.byte_ready = rdy_flag;
    rep.byte_value = rx_byte;
    rep.phase = bus_ph;
    return rep;
  endfunction

  function automatic int limit_jitter(int jitter, int room);
    return (room < jitter) ? room : jitter;
  endfunction

  task automatic send_tick(input logic lvl, input logic ack);
    in_t req;
    req.line_level = lvl;
    req.host_ack = ack;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    expected_reports.push_back(advance_receiver_model(req));
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic program_register(input logic [CfgIdxW-1:0] idx,
                                  input logic [CountW-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_SAMPLE_POINT: samp_pt = value;
      REG_RESET_POINT:  rst_pt = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_points(input logic [CountW-1:0] sp, input logic [CountW-1:0] rp);
    program_register(REG_SAMPLE_POINT, sp);
    program_register(REG_RESET_POINT, rp);
  endtask

  // A well-formed frame is a reset pulse, a release, and eight bit slots.
  // A bad bit gets a slot long enough to hit the reset point in read.
  task automatic send_frame(input logic [ByteW-1:0] data, input int jitter, input int ack_pct,
                            input bit ack_on_done, input int bad_bit);
    int sp;
    int rp;
    int hi;
    int len;
    int n;
    sp = int'(samp_pt);
    rp = int'(rst_pt);
    n = 0;
    while ((bus_ph != PH_IDLE || n == 0) && n < 300) begin
      send_tick(1'b0, $urandom_range(99) < ack_pct);
      n++;
    end
    repeat (rp + 1 + $urandom_range(jitter)) send_tick(1'b1, $urandom_range(99) < ack_pct);
    repeat (1 + $urandom_range(jitter)) send_tick(1'b0, $urandom_range(99) < ack_pct);
    for (int i = 0; i < 8; i++) begin
      if (data[i]) begin
        hi = 1 + $urandom_range(limit_jitter(jitter, sp - 1));
        len = sp + 1 + $urandom_range(limit_jitter(jitter, rp - sp - 1));
      end else begin
        hi = sp + 1 + $urandom_range(limit_jitter(jitter, rp - sp - 2));
        len = hi + 1 + $urandom_range(limit_jitter(jitter, rp - hi - 1));
      end
      if (i == bad_bit) len = rp + 1 + $urandom_range(jitter);
      for (int j = 0; j < len; j++) begin
        send_tick(j < hi, (ack_on_done && i == 7 && j == sp) || ($urandom_range(99) < ack_pct));
      end
    end
  endtask

  task automatic send_noise(input int total, input int maxrun);
    int left;
    int run;
    logic lvl;
    left = total;
    while (left > 0) begin
      lvl = 1'($urandom_range(1));
      run = $urandom_range(maxrun, 1);
      repeat (run) send_tick(lvl, $urandom_range(9) == 0);
      left -= run;
    end
  endtask

  // The acknowledge in the tick that completes the byte must not clear the flag.
  task automatic test_directed_byte();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_points(8'd1, 8'd3);
    send_tick(1'b0, 1'b1);
    send_frame(8'hA5, 0, 0, 1'b1, -1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    wait_idle();
  endtask

  // Both compare points at zero match only when the counter wraps, so the
  // pulse is judged and the bit is sampled there.
  task automatic test_counter_wrap();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_points(8'd0, 8'd0);
    repeat (257) send_tick(1'b1, $urandom_range(9) == 0);
    send_tick(1'b0, 1'b0);
    repeat (257) send_tick(1'b1, $urandom_range(9) == 0);
    wait_idle();
  endtask

  task automatic test_extreme_points();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_points(8'd255, 8'd1);
    send_noise(30, 6);
    set_points(8'd1, 8'd255);
    send_noise(30, 6);
    wait_idle();
  endtask

  task automatic test_random_traffic(input logic [CountW-1:0] sp, input logic [CountW-1:0] rp,
                                     input int send_pct, input int recv_pct, input int n_items);
    int stop_at;
    int pick;
    logic [ByteW-1:0] data;
    set_points(sp, rp);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    stop_at = ticks_sent + n_items;
    while (ticks_sent < stop_at) begin
      pick = $urandom_range(9);
      case ($urandom_range(7))
        0: data = 8'h00;
        1: data = 8'hFF;
        default: data = 8'($urandom);
      endcase
      if (pick < 7) send_frame(data, 3, 10, 1'b0, -1);
      else if (pick == 7) send_frame(data, 3, 10, 1'b0, $urandom_range(7));
      else send_noise($urandom_range(20, 5), int'(rp) + 3);
    end
    wait_idle();
  endtask

  // The receiver holds off long enough for the output buffer to fill while
  // the sender keeps offering requests.
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_points(8'd2, 8'd6);
    send_frame(8'($urandom), 3, 10, 1'b0, -1);
    hold_off_left = HoldOffCycles;
    send_frame(8'($urandom), 3, 10, 1'b0, -1);
    wait_idle();
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ready <= 1'b0;
        hold_off_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    out_t exp_rep;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        fail_count++;
      end else begin
        exp_rep = expected_reports.pop_front();
        if (out_data.byte_ready !== exp_rep.byte_ready) begin
          $display("%0t: byte_ready expected %0d actual %0d", $time,
                   exp_rep.byte_ready, out_data.byte_ready);
          fail_count++;
        end
        if (out_data.byte_value !== exp_rep.byte_value) begin
          $display("%0t: byte_value expected %h actual %h", $time,
                   exp_rep.byte_value, out_data.byte_value);
          fail_count++;
        end
        if (out_data.phase !== exp_rep.phase) begin
          $display("%0t: phase expected %0d actual %0d", $time, exp_rep.phase, out_data.phase);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("%0t: no request or result moved for %0d cycles", $time, IdleLimit);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_SAMPLE_POINT;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_byte();
    test_counter_wrap();
    test_extreme_points();
    test_random_traffic(8'd2, 8'd7, 0, 0, 30);
    test_random_traffic(8'd3, 8'd9, 61, 0, 30);
    test_random_traffic(8'd1, 8'd4, 0, 61, 30);
    test_random_traffic(8'd4, 8'd20, 16, 16, 30);
    test_output_hold_off();
    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
